FILE: rtl/core/key_value_table_core_macros.svh
// ----------------------------------------------------------------------------
// Key/value table assertion macros
// Concurrent assertion helpers shared by the key/value table RTL.
// ----------------------------------------------------------------------------
`ifndef KEY_VALUE_TABLE_CORE_MACROS_SVH
`define KEY_VALUE_TABLE_CORE_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define KVT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("key/value table assertion failed");

// next-cycle implication
`define KVT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("key/value table assertion failed");

// condition that must always hold
`define KVT_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("key/value table assertion failed");

`else

`define KVT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define KVT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define KVT_ASSERT_ALWAYS(label, clk, rst_n, cond)

`endif

`endif

FILE: rtl/core/kvt_pkg.sv
// ----------------------------------------------------------------------------
// Key/value table package
// Sizes, request and status codes, and the structs shared by the table RTL.
// ----------------------------------------------------------------------------
package kvt_pkg;

	// table geometry
	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;
	localparam int TYPE_W  = 3;
	localparam int STAT_W  = 2;

	typedef logic [IDX_W-1:0] idx_t;

	// request kinds
	localparam logic [TYPE_W-1:0] REQ_INSERT   = 3'd0;
	localparam logic [TYPE_W-1:0] REQ_GET      = 3'd1;
	localparam logic [TYPE_W-1:0] REQ_CONTAINS = 3'd2;
	localparam logic [TYPE_W-1:0] REQ_DELETE   = 3'd3;
	localparam logic [TYPE_W-1:0] REQ_CLEAR    = 3'd4;

	// result status codes
	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STAT_W-1:0] ST_EXISTS    = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

	// request payload
	typedef struct packed {
		logic [TYPE_W-1:0]       req_type;
		logic signed [KEY_W-1:0] req_key;
		logic signed [VAL_W-1:0] req_value;
	} kvt_req_t;

	// result payload
	typedef struct packed {
		logic [STAT_W-1:0]       status;
		logic                    found;
		logic signed [VAL_W-1:0] read_value;
	} kvt_rsp_t;

	// lookup result from the entry array
	typedef struct packed {
		logic                    hit;
		idx_t                    hit_idx;
		logic signed [VAL_W-1:0] hit_value;
		logic                    free;
		idx_t                    free_idx;
	} kvt_match_t;

	// update command to the entry array
	typedef struct packed {
		logic                    insert;
		logic                    remove;
		logic                    clear;
		idx_t                    idx;
		logic signed [KEY_W-1:0] key;
		logic signed [VAL_W-1:0] value;
	} kvt_wr_t;

endpackage

FILE: rtl/core/kvt_cam.sv
// ----------------------------------------------------------------------------
// Key/value table entry array
// Holds the entries, compares one key against all of them in parallel,
// picks the lowest free slot and applies insert, delete and clear updates.
// ----------------------------------------------------------------------------
`include "key_value_table_core_macros.svh"

module kvt_cam import kvt_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic signed [KEY_W-1:0] lookup_key,
	input  kvt_wr_t                 wr,
	output kvt_match_t              match
);

	logic [ENTRIES-1:0]      valid_q;
	logic signed [KEY_W-1:0] key_q [ENTRIES];
	logic signed [VAL_W-1:0] val_q [ENTRIES];

	logic [ENTRIES-1:0] hit_mask;

	// parallel compare against every valid entry
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			hit_mask[i] = valid_q[i] && (key_q[i] == lookup_key);
		end
	end

	// hit index, hit value (keys are unique, so an AND-OR mux) and lowest free slot
	always_comb begin
		match.hit       = |hit_mask;
		match.free      = ~&valid_q;
		match.hit_idx   = '0;
		match.free_idx  = '0;
		match.hit_value = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (hit_mask[i]) begin
				match.hit_idx = idx_t'(i);
			end
			if (!valid_q[i]) begin
				match.free_idx = idx_t'(i);
			end
		end
		for (int i = 0; i < ENTRIES; i++) begin
			match.hit_value = match.hit_value | (hit_mask[i] ? val_q[i] : '0);
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.clear) begin
			valid_q <= '0;
		end else begin
			if (wr.insert) begin
				valid_q[wr.idx] <= 1'b1;
			end
			if (wr.remove) begin
				valid_q[wr.idx] <= 1'b0;
			end
		end
	end

	// key and value storage, no reset
	always_ff @(posedge clk) begin
		if (wr.insert) begin
			key_q[wr.idx] <= wr.key;
			val_q[wr.idx] <= wr.value;
		end
	end

	// assertions
	`KVT_ASSERT_ALWAYS(a_unique_keys, clk, arst_n, $onehot0(hit_mask))
	`KVT_ASSERT_IMPLIES(a_insert_free_slot, clk, arst_n, wr.insert, !valid_q[wr.idx])
	`KVT_ASSERT_NEXT(a_clear_empties, clk, arst_n, wr.clear, valid_q == '0)

endmodule

FILE: rtl/core/key_value_table_core.sv
// ----------------------------------------------------------------------------
// Key/value table core
// A 16-entry fully associative table of 32-bit keys and values. Each request
// (insert, get, contains, delete, clear) yields one response with a status,
// a found flag and the read value. An accepted request is registered and
// looked up against all entries in the next cycle; once the response register
// is free or draining, it is applied to the table and its response is
// registered. One request per cycle is sustained when the response side does
// not stall.
// The rate is set by the combinational parallel key compare and lowest-free-
// slot pick in the entry array; the table update is written at the end of
// the lookup, so the next request always sees it. Inserts of a present key
// report "exists", inserts into a full table report "full".
// ----------------------------------------------------------------------------
`include "key_value_table_core_macros.svh"

module key_value_table_core import kvt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  kvt_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output kvt_rsp_t rsp
);

	logic       valid_s1;
	kvt_req_t   req_s1;
	logic       rsp_valid_q;
	kvt_rsp_t   rsp_q;
	logic       adv;
	kvt_match_t match;
	kvt_wr_t    wr;
	kvt_rsp_t   rsp_d;

	// stage 1 moves on when the response register is free or draining
	assign adv       = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_valid && !req_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	kvt_cam u_cam (
		.clk        (clk),
		.arst_n     (arst_n),
		.lookup_key (req_s1.req_key),
		.wr         (wr),
		.match      (match)
	);

	// request decode: response fields and table update
	always_comb begin
		rsp_d.status     = ST_OK;
		rsp_d.found      = match.hit;
		rsp_d.read_value = '0;
		wr.insert        = 1'b0;
		wr.remove        = 1'b0;
		wr.clear         = 1'b0;
		wr.idx           = match.hit ? match.hit_idx : match.free_idx;
		wr.key           = req_s1.req_key;
		wr.value         = req_s1.req_value;
		case (req_s1.req_type)
			REQ_INSERT: begin
				if (match.hit) begin
					rsp_d.status = ST_EXISTS;
				end else if (match.free) begin
					wr.insert = adv;
				end else begin
					rsp_d.status = ST_FULL;
				end
			end
			REQ_GET: begin
				if (match.hit) begin
					rsp_d.read_value = match.hit_value;
				end else begin
					rsp_d.status = ST_NOT_FOUND;
				end
			end
			REQ_CONTAINS: begin
				if (!match.hit) begin
					rsp_d.status = ST_NOT_FOUND;
				end
			end
			REQ_DELETE: begin
				if (match.hit) begin
					wr.remove = adv;
				end else begin
					rsp_d.status = ST_NOT_FOUND;
				end
			end
			REQ_CLEAR: begin
				wr.clear = adv;
			end
			default: begin
			end
		endcase
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// assertions
	`KVT_ASSERT_NEXT(a_s1_held_on_stall, clk, arst_n, valid_s1 && !adv, valid_s1)
	`KVT_ASSERT_IMPLIES(a_exists_is_found, clk, arst_n, rsp_valid_q && (rsp_q.status == ST_EXISTS), rsp_q.found)
	`KVT_ASSERT_IMPLIES(a_value_only_on_hit, clk, arst_n, rsp_valid_q && (rsp_q.read_value != '0), rsp_q.found && (rsp_q.status == ST_OK))

endmodule
